/* rtl/assert_macros.svh */
// Assertion macros used by the encoder core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define DQNE_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define DQNE_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DQNE_ASSERT(name, clk, rst_n, prop, msg)
`define DQNE_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

/* rtl/dqne_pkg.sv */
// Types and constants of the DNS question name encoder.
package dqne_pkg;

    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned WORD_W  = 16;
    localparam int unsigned USER_W  = 2;

    localparam logic [CHAR_W-1:0] CH_DOT = 8'd46;
    localparam logic [CHAR_W-1:0] CH_END = 8'd0;

    localparam logic CFG_QUERY_TYPE  = 1'b0;
    localparam logic CFG_QUERY_CLASS = 1'b1;

    // tuser bit positions
    localparam int unsigned USER_DONE = 0;
    localparam int unsigned USER_OVF  = 1;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_LEN  = 8'b0000_0010,
        S_RD   = 8'b0000_0100,
        S_DATA = 8'b0000_1000,
        S_ROOT = 8'b0001_0000,
        S_THI  = 8'b0010_0000,
        S_TLO  = 8'b0100_0000,
        S_CHI  = 8'b1000_0000
    } t_state;

    // Class low byte ends the question; it reuses the trailer path of S_CHI.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              done;
        logic              ovf;
    } t_out_word;

endpackage

/* rtl/dqne_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module dqne_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/dns_question_name_encoder_core.sv */
// Top level of the DNS question name encoder: label buffer and byte sequencer.
//
//  channel   dir  handshake                        payload
//  s_axis    in   s_axis_tvalid / s_axis_tready    tdata[7:0] name_char
//  m_axis    out  m_axis_tvalid / m_axis_tready    tdata[7:0] out_byte, tlast last_of_run,
//                                                  tuser[0] question_done,
//                                                  tuser[1] label_overflow
//  cfg       in   i_cfg_we                         i_cfg_idx, i_cfg_data[15:0]
//
// An ordinary character is written into the label RAM while the label has room.
// A dot emits the length byte and then each byte of the label; the terminating zero does
// the same and adds the root zero, type and class, or just those with no label pending.
// Each label byte is read from the RAM port in S_RD and loaded into the output word
// in S_DATA; one index counter walks the RAM.
// s_axis_tready is high only while the sequencer sits idle. Back pressure on
// m_axis holds the sequencer in place. Reset is synchronous and clears control
// state; the label RAM needs no clearing since only written entries are read.
`include "assert_macros.svh"

module dns_question_name_encoder_core
    import dqne_pkg::*;
#(
    parameter int unsigned LABEL_MAX = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // name_char [7:0]
    input  logic [CHAR_W-1:0]     s_axis_tdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // out_byte [7:0]
    output logic [BYTE_W-1:0]     m_axis_tdata,
    // question_done [0], label_overflow [1]
    output logic [USER_W-1:0]     m_axis_tuser,
    output logic                  m_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [WORD_W-1:0]     i_cfg_data
);

    localparam int unsigned CNT_W = $clog2(LABEL_MAX + 1);
    localparam int unsigned IDX_W = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(LABEL_MAX);

    // Configuration registers
    logic [WORD_W-1:0] r_qtype, r_qclass;

    // Label state
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_ovf,   n_ovf;
    logic [CNT_W-1:0]  r_idx,   n_idx;
    logic              r_end,   n_end;
    t_state            r_state, n_state;

    // Output register
    logic              r_m_valid, n_m_valid;
    t_out_word         r_m_word,  n_m_word;

    logic              acc, slot_free, is_dot, is_end, ram_we, ram_re;
    logic              idx_last;
    logic [BYTE_W-1:0] ram_rdata;

    assign s_axis_tready = (r_state == S_IDLE);
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign is_dot        = (s_axis_tdata == CH_DOT);
    assign is_end        = (s_axis_tdata == CH_END);
    assign slot_free     = !r_m_valid || m_axis_tready;
    assign idx_last      = ((r_idx + 1'b1) == r_count);

    // Store an ordinary character while the buffer has room.
    assign ram_we = acc && !is_dot && !is_end && (r_count < CNT_MAX);
    assign ram_re = (r_state == S_RD);

    dqne_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (LABEL_MAX)
    ) u_label_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (s_axis_tdata),
        .i_re    (ram_re),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_idx     = r_idx;
        n_end     = r_end;
        n_m_valid = r_m_valid && !m_axis_tready;
        n_m_word  = r_m_word;

        unique case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (is_dot) begin
                        n_end   = 1'b0;
                        n_state = S_LEN;
                    end else if (is_end) begin
                        n_end   = 1'b1;
                        n_state = (r_count != '0) ? S_LEN : S_ROOT;
                    end else if (r_count < CNT_MAX) begin
                        n_count = r_count + 1'b1;
                    end else begin
                        n_ovf = 1'b1;
                    end
                end
            end
            S_LEN: begin
                if (slot_free) begin
                    n_m_valid      = 1'b1;
                    n_m_word.data  = BYTE_W'(r_count);
                    n_m_word.last  = (r_count == '0) && !r_end;
                    n_m_word.done  = 1'b0;
                    n_m_word.ovf   = r_ovf;
                    n_idx          = '0;
                    if (r_count == '0) begin
                        // Empty label from a dot: lone zero length, back to idle.
                        n_ovf   = 1'b0;
                        n_state = r_end ? S_ROOT : S_IDLE;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                n_state = S_DATA;
            end
            S_DATA: begin
                if (slot_free) begin
                    n_m_valid      = 1'b1;
                    n_m_word.data  = ram_rdata;
                    n_m_word.last  = idx_last && !r_end;
                    n_m_word.done  = 1'b0;
                    n_m_word.ovf   = r_ovf;
                    n_idx          = r_idx + 1'b1;
                    if (idx_last) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = r_end ? S_ROOT : S_IDLE;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_ROOT: begin
                if (slot_free) begin
                    n_m_valid = 1'b1;
                    n_m_word  = '{data: '0, last: 1'b0, done: 1'b0, ovf: 1'b0};
                    n_state   = S_THI;
                end
            end
            S_THI: begin
                if (slot_free) begin
                    n_m_valid = 1'b1;
                    n_m_word  = '{data: r_qtype[15:8], last: 1'b0, done: 1'b0, ovf: 1'b0};
                    n_state   = S_TLO;
                end
            end
            S_TLO: begin
                if (slot_free) begin
                    n_m_valid = 1'b1;
                    n_m_word  = '{data: r_qtype[7:0], last: 1'b0, done: 1'b0, ovf: 1'b0};
                    n_state   = S_CHI;
                end
            end
            S_CHI: begin
                // Emit class high byte here, then the class low byte via r_end.
                if (slot_free) begin
                    n_m_valid = 1'b1;
                    if (r_end) begin
                        n_m_word = '{data: r_qclass[15:8], last: 1'b0, done: 1'b0,
                                     ovf: 1'b0};
                        n_end    = 1'b0;
                    end else begin
                        n_m_word = '{data: r_qclass[7:0], last: 1'b1, done: 1'b1,
                                     ovf: 1'b0};
                        n_count  = '0;
                        n_ovf    = 1'b0;
                        n_state  = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_idx     <= '0;
            r_end     <= 1'b0;
            r_m_valid <= 1'b0;
            r_qtype   <= WORD_W'(1);
            r_qclass  <= WORD_W'(1);
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_ovf     <= n_ovf;
            r_idx     <= n_idx;
            r_end     <= n_end;
            r_m_valid <= n_m_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_QUERY_TYPE:  r_qtype  <= i_cfg_data;
                    CFG_QUERY_CLASS: r_qclass <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Payload of the output word; no reset needed.
    always_ff @(posedge i_clk) begin
        r_m_word <= n_m_word;
    end

    assign m_axis_tvalid          = r_m_valid;
    assign m_axis_tdata           = r_m_word.data;
    assign m_axis_tlast           = r_m_word.last;
    assign m_axis_tuser[USER_DONE] = r_m_word.done;
    assign m_axis_tuser[USER_OVF]  = r_m_word.ovf;

    `DQNE_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_MAX, "label count past buffer")
    `DQNE_ASSERT(a_ovf_full, i_clk, i_rst_n, r_ovf |-> (r_count == CNT_MAX), "overflow without full buffer")
    `DQNE_ASSERT(a_done_last, i_clk, i_rst_n, (r_m_valid && r_m_word.done) |-> r_m_word.last, "question end word not last")
    `DQNE_ASSERT(a_read_in_range, i_clk, i_rst_n, (r_state == S_RD) |-> (r_idx < r_count), "label read beyond count")
    `DQNE_ASSERT(a_plain_char_idle, i_clk, i_rst_n, (acc && !is_dot && !is_end) |=> (r_state == S_IDLE), "plain character left idle")

endmodule

/* sim/dqne_tb_pkg.sv */
// Scoreboard for the DNS question name encoder: label predictor and expected byte queue.
package dqne_tb_pkg;

    import dqne_pkg::*;

    localparam int unsigned LABEL_DEPTH = 32;

    class question_scoreboard;

        t_out_word         expected_bytes[$];
        logic [BYTE_W-1:0] label_buf [LABEL_DEPTH];
        int unsigned       label_len;
        logic              label_cut;
        logic [WORD_W-1:0] qtype;
        logic [WORD_W-1:0] qclass;
        int unsigned       mismatches;

        function new();
            label_len  = 0;
            label_cut  = 1'b0;
            qtype      = 16'd1;
            qclass     = 16'd1;
            mismatches = 0;
        endfunction

        function void set_register(logic idx, logic [WORD_W-1:0] value);
            if (idx == CFG_QUERY_TYPE) begin
                qtype = value;
            end else begin
                qclass = value;
            end
        endfunction

        function void push_byte(logic [BYTE_W-1:0] b, logic ovf, logic done);
            t_out_word w;
            w.data = b;
            w.last = 1'b0;
            w.done = done;
            w.ovf  = ovf;
            expected_bytes.push_back(w);
        endfunction

        // Length byte, then the buffered characters, all tagged with the cut flag.
        function void flush_label();
            push_byte(8'(label_len), label_cut, 1'b0);
            for (int unsigned i = 0; i < label_len; i++) begin
                push_byte(label_buf[i], label_cut, 1'b0);
            end
            label_len = 0;
            label_cut = 1'b0;
        endfunction

        function void note_char(logic [CHAR_W-1:0] c);
            t_out_word tail;
            if (c == CH_DOT) begin
                flush_label();
            end else if (c == CH_END) begin
                if (label_len != 0) begin
                    flush_label();
                end
                push_byte(8'h00, 1'b0, 1'b0);
                push_byte(qtype[15:8], 1'b0, 1'b0);
                push_byte(qtype[7:0], 1'b0, 1'b0);
                push_byte(qclass[15:8], 1'b0, 1'b0);
                push_byte(qclass[7:0], 1'b0, 1'b1);
            end else begin
                // Store while there is room, otherwise drop and mark the label cut.
                if (label_len < LABEL_DEPTH) begin
                    label_buf[label_len] = c;
                    label_len++;
                end else begin
                    label_cut = 1'b1;
                end
                return;
            end
            tail = expected_bytes.pop_back();
            tail.last = 1'b1;
            expected_bytes.push_back(tail);
        endfunction

        function void check_byte(t_out_word got);
            t_out_word want;
            if (expected_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: unexpected byte data=%h last=%b done=%b ovf=%b",
                             got.data, got.last, got.done, got.ovf);
                end
                return;
            end
            want = expected_bytes.pop_front();
            if (got.data !== want.data || got.last !== want.last ||
                got.done !== want.done || got.ovf !== want.ovf) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: byte mismatch exp data=%h last=%b done=%b ovf=%b",
                             want.data, want.last, want.done, want.ovf);
                    $display("                     got data=%h last=%b done=%b ovf=%b",
                             got.data, got.last, got.done, got.ovf);
                end
            end
        endfunction

        function int unsigned pending();
            return expected_bytes.size();
        endfunction

    endclass

endpackage

/* sim/dns_question_name_encoder_core_tb.sv */
// Self-checking bench for the DNS question name encoder core.
module dns_question_name_encoder_core_tb;

    import dqne_pkg::*;
    import dqne_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles without any handshake or register write before the run is declared hung.
    // The longest legal quiet stretch is a long sender gap or receiver stall from pick_gap
    // plus the read and load steps of a label byte, so this limit is many times over.
    localparam int unsigned HANG_LIMIT = 4000;
    // Settle time after the last expected byte: an ordinary character may still be
    // landing in the label store.
    localparam int unsigned SETTLE_CYCLES = 8;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic [CHAR_W-1:0] s_axis_tdata  = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [BYTE_W-1:0] m_axis_tdata;
    logic [USER_W-1:0] m_axis_tuser;
    logic              m_axis_tlast;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic              i_cfg_we      = 1'b0;
    logic              i_cfg_idx     = CFG_QUERY_TYPE;
    logic [WORD_W-1:0] i_cfg_data    = '0;

    question_scoreboard sb;
    int unsigned        chars_sent  = 0;
    int unsigned        idle_cycles = 0;
    int unsigned        ready_hold  = 0;
    int unsigned        rx_stall;

    dns_question_name_encoder_core #(
        .LABEL_MAX(LABEL_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),   // name_char [7:0]
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // out_byte [7:0]
        .m_axis_tuser  (m_axis_tuser),   // question_done [0], label_overflow [1]
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Gap length for either side: mostly none, some short, a few long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(40, 10);
    endfunction

    // Receiver: alternate runs of ready with stalls. A run is sometimes long, which
    // gives stretches where the output never backs up.
    always @(posedge i_clk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else if (m_axis_tready) begin
            rx_stall = pick_gap();
            if (rx_stall != 0) begin
                m_axis_tready <= 1'b0;
                ready_hold    <= rx_stall - 1;
            end else begin
                ready_hold <= ($urandom_range(19) == 0) ? $urandom_range(300, 150)
                                                        : $urandom_range(10, 1);
            end
        end else begin
            m_axis_tready <= 1'b1;
            ready_hold    <= $urandom_range(10, 1);
        end
    end

    // Check every output word accepted after reset against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_byte('{data: m_axis_tdata, last: m_axis_tlast,
                            done: m_axis_tuser[USER_DONE], ovf: m_axis_tuser[USER_OVF]});
        end
    end

    // Hang detector: count cycles in which neither channel moves a word and no register is written.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
        begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= HANG_LIMIT) begin
                $display("ERROR: no progress for %0d cycles", HANG_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Present one character, hold it until the core takes it, then feed the predictor.
    task automatic send_char(input logic [CHAR_W-1:0] c, input bit no_gaps);
        int unsigned gap;
        gap = no_gaps ? 0 : pick_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= c;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_char(c);
        chars_sent++;
    endtask

    // Drop valid, wait for every predicted byte, then let the label store settle.
    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write type then class on back-to-back cycles; only called with the core idle.
    task automatic write_config(input logic [WORD_W-1:0] qtype, input logic [WORD_W-1:0] qclass);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_QUERY_TYPE;
        i_cfg_data <= qtype;
        @(posedge i_clk);
        sb.set_register(CFG_QUERY_TYPE, qtype);
        i_cfg_idx  <= CFG_QUERY_CLASS;
        i_cfg_data <= qclass;
        @(posedge i_clk);
        sb.set_register(CFG_QUERY_CLASS, qclass);
        i_cfg_we   <= 1'b0;
    endtask

    // One random name: up to four labels, some empty (leading or doubled dots), some
    // long enough to fill or overrun the label store, sometimes a trailing dot.
    task automatic send_random_name();
        int unsigned n_labels;
        int unsigned len;
        int unsigned r;
        bit          no_gaps;
        logic [CHAR_W-1:0] c;
        no_gaps  = ($urandom_range(4) == 0);
        n_labels = $urandom_range(4);
        for (int unsigned l = 0; l < n_labels; l++) begin
            r = $urandom_range(99);
            if (r < 8) begin
                len = 0;
            end else if (r < 16) begin
                len = $urandom_range(36, 30);
            end else begin
                len = $urandom_range(10, 1);
            end
            if (l != 0) begin
                send_char(CH_DOT, no_gaps);
            end
            repeat (len) begin
                // Half plain letters, half any byte that is neither a dot nor the end mark.
                if ($urandom_range(1) != 0) begin
                    c = 8'h61 + 8'($urandom_range(25));
                end else begin
                    c = 8'($urandom_range(255, 1));
                    if (c == CH_DOT) begin
                        c = 8'h2D;
                    end
                end
                send_char(c, no_gaps);
            end
        end
        if (n_labels != 0 && $urandom_range(6) == 0) begin
            send_char(CH_DOT, no_gaps);
        end
        send_char(CH_END, no_gaps);
    endtask

    // Opening names, run with the reset type and class:
    //   empty name; two labels of extreme bytes; a lone dot (empty label, then the end
    //   mark with nothing pending); an empty label between two dots and a trailing dot.
    logic [CHAR_W-1:0] opening_chars [15] = '{
        CH_END,
        8'hFF, 8'h01, CH_DOT, 8'h80, 8'h7F, CH_END,
        CH_DOT, CH_END,
        8'h61, CH_DOT, CH_DOT, 8'h62, CH_DOT, CH_END
    };

    // Register settings per random phase: both extremes each way, then random values.
    logic [WORD_W-1:0] phase_type  [4];
    logic [WORD_W-1:0] phase_class [4];

    initial begin
        sb = new();
        phase_type[0]  = 16'hFFFF;
        phase_class[0] = 16'h0000;
        phase_type[1]  = 16'h0000;
        phase_class[1] = 16'hFFFF;
        phase_type[2]  = 16'($urandom_range(65535));
        phase_class[2] = 16'($urandom_range(65535));
        phase_type[3]  = 16'($urandom_range(65535));
        phase_class[3] = 16'($urandom_range(65535));

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (opening_chars[i]) begin
            send_char(opening_chars[i], 1'b0);
        end
        settle_block();

        // Each phase ends on a complete name, so the label state is clear at the write.
        for (int p = 0; p < 4; p++) begin
            write_config(phase_type[p], phase_class[p]);
            while (chars_sent < 15 + 50 * (p + 1)) begin
                send_random_name();
            end
            settle_block();
        end

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/dqne_pkg.sv
rtl/dqne_ram.sv
rtl/dns_question_name_encoder_core.sv
sim/dqne_tb_pkg.sv
sim/dns_question_name_encoder_core_tb.sv
